// ===== sv/ucbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucbs_pkg
// Shared types and constants of the utf-8 chunk boundary sanitizer: chunk
// capacity, byte codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ucbs_pkg;

  localparam int CHUNK_BYTES = 64;
  localparam int ADDR_W      = $clog2(CHUNK_BYTES);
  localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);
  localparam int LEN_W       = 7;

  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_FE    = 8'hFE;
  localparam logic [7:0] BOM8_B0    = 8'hEF;
  localparam logic [7:0] BOM8_B1    = 8'hBB;
  localparam logic [7:0] BOM8_B2    = 8'hBF;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TRIM_RD,
    S_TRIM_EV,
    S_FIX,
    S_EMIT
  } ucbs_state_e;

  typedef struct packed {
    logic load;        // byte transfer accepted
    logic close;       // accepted byte ends the chunk
    logic check;       // evaluate byte order marks
    logic status_out;  // send the utf-16 status result
    logic trim_rd;     // read the byte before the current length
    logic trim_step;   // evaluate the byte read for the tail walk
    logic fix;         // empty-after-trim fixup, rewind emit index
    logic emit_rd;     // read the next byte to send
  } ucbs_cmd_t;

  typedef struct packed {
    logic utf16;       // utf-16 byte order mark at file start
    logic more;        // chunk is not the file's last
    logic len_zero;    // working length is zero
    logic step_cont;   // byte just read is a continuation byte
    logic emit_last;   // emit index points at the last kept byte
  } ucbs_sts_t;

endpackage

// ===== sv/ucbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucbs_ctrl
// Controller: sequences load, mark check, tail walk, length fixup and emit.
// ----------------------------------------------------------------------------
module ucbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               chunk_end_i,
  input  ucbs_pkg::ucbs_sts_t sts_i,
  output ucbs_pkg::ucbs_cmd_t cmd_o,
  output logic               busy_o
);
  import ucbs_pkg::*;

  ucbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.close = chunk_end_i;
          if (chunk_end_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.utf16) begin
          cmd_o.status_out = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.more) begin
          state_d = S_TRIM_RD;
        end else begin
          state_d = S_FIX;
        end
      end
      S_TRIM_RD: begin
        if (sts_i.len_zero) begin
          state_d = S_FIX;
        end else begin
          cmd_o.trim_rd = 1'b1;
          state_d       = S_TRIM_EV;
        end
      end
      S_TRIM_EV: begin
        cmd_o.trim_step = 1'b1;
        state_d = sts_i.step_cont ? S_TRIM_RD : S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        if (sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== sv/ucbs_datapath.sv =====
// ----------------------------------------------------------------------------
// ucbs_datapath
// Datapath: chunk store, byte count, mark detection, tail walk registers and
// the result registers.
// ----------------------------------------------------------------------------
module ucbs_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ucbs_pkg::ucbs_cmd_t   cmd_i,
  output ucbs_pkg::ucbs_sts_t   sts_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  at_file_start_i,
  input  logic                  more_follows_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  output logic                  status_o,
  output logic [ucbs_pkg::LEN_W-1:0] valid_length_o
);
  import ucbs_pkg::*;

  logic [7:0]        mem [CHUNK_BYTES];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  n_q, len_q, tail_q;
  logic [ADDR_W-1:0] idx_q;
  logic [7:0]        b0_q, b1_q, b2_q;
  logic              start_q, more_q, bom_q;
  logic              room, wr_en;
  logic [CNT_W-1:0]  n_next, len_m1;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr, rd_addr_q;
  logic [7:0]        rd_data_q;
  logic              rd_vld_q, rd_last_q;
  logic [7:0]        eval_byte, clean_byte;
  logic [CNT_W-1:0]  expect_cnt;
  logic              utf16, bom8;
  logic              out_vld_q, out_last_q, out_status_q;
  logic [7:0]        out_byte_q;
  logic [CNT_W-1:0]  out_len_q;

  assign room   = (cnt_q < CNT_W'(CHUNK_BYTES));
  assign wr_en  = cmd_i.load && room;
  assign n_next = room ? cnt_q + CNT_W'(1) : cnt_q;
  assign len_m1 = len_q - CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.close) begin
      cnt_d = '0;
    end else if (wr_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // chunk store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[ADDR_W-1:0]] <= data_byte_i;
    end
  end

  assign rd_en   = cmd_i.trim_rd || cmd_i.emit_rd;
  assign rd_addr = cmd_i.trim_rd ? len_m1[ADDR_W-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // first three bytes kept aside for the mark checks
  always_ff @(posedge clk_i) begin
    if (wr_en && cnt_q == CNT_W'(0)) b0_q <= data_byte_i;
    if (wr_en && cnt_q == CNT_W'(1)) b1_q <= data_byte_i;
    if (wr_en && cnt_q == CNT_W'(2)) b2_q <= data_byte_i;
  end

  assign utf16 = start_q && (n_q >= CNT_W'(2)) &&
                 ((b0_q == BYTE_FF && b1_q == BYTE_FE) ||
                  (b0_q == BYTE_FE && b1_q == BYTE_FF));
  assign bom8  = start_q && (n_q >= CNT_W'(3)) &&
                 b0_q == BOM8_B0 && b1_q == BOM8_B1 && b2_q == BOM8_B2;

  // utf-8 mark bytes read back as spaces
  assign eval_byte = (bom_q && rd_addr_q < ADDR_W'(3)) ? BYTE_SPACE : rd_data_q;

  always_comb begin
    if (eval_byte[7:5] == 3'b110) begin
      expect_cnt = CNT_W'(1);
    end else if (eval_byte[7:4] == 4'b1110) begin
      expect_cnt = CNT_W'(2);
    end else if (eval_byte[7:3] == 5'b11110) begin
      expect_cnt = CNT_W'(3);
    end else begin
      expect_cnt = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      n_q     <= n_next;
      len_q   <= n_next;
      tail_q  <= '0;
      start_q <= at_file_start_i;
      more_q  <= more_follows_i;
    end
    if (cmd_i.check) begin
      bom_q <= bom8;
    end
    if (cmd_i.trim_step && eval_byte[7]) begin
      if (!eval_byte[6]) begin
        tail_q <= tail_q + CNT_W'(1);
        len_q  <= len_m1;
      end else if (tail_q == expect_cnt) begin
        len_q <= len_q + tail_q;
      end else begin
        len_q <= len_m1;
      end
    end
    if (cmd_i.fix) begin
      if (len_q == '0) begin
        len_q <= n_q;
      end
      idx_q <= '0;
    end
    if (cmd_i.emit_rd) begin
      idx_q <= idx_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.emit_rd;
      rd_last_q <= cmd_i.emit_rd && sts_o.emit_last;
      out_vld_q <= cmd_i.status_out || rd_vld_q;
    end
  end

  always_comb begin
    clean_byte = eval_byte;
    if (eval_byte == BYTE_CR || eval_byte == BYTE_NUL) begin
      clean_byte = BYTE_SPACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.status_out) begin
      out_byte_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= 1'b1;
      out_len_q    <= n_q;
    end else if (rd_vld_q) begin
      out_byte_q   <= clean_byte;
      out_last_q   <= rd_last_q;
      out_status_q <= 1'b0;
      out_len_q    <= len_q;
    end
  end

  assign sts_o.utf16     = utf16;
  assign sts_o.more      = more_q;
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.step_cont = (eval_byte[7:6] == 2'b10);
  assign sts_o.emit_last = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = out_byte_q;
  assign out_last_o     = out_last_q;
  assign status_o       = out_status_q;
  assign valid_length_o = LEN_W'(out_len_q);

endmodule

// ===== sv/utf8_chunk_boundary_sanitizer_core.sv =====
// Bytes load one per cycle while busy is low; a byte with chunk_end starts processing.
// Processing: a mark check, then, when more follows, a tail walk that reads and
// evaluates each byte it visits, a length fixup and a read of each kept byte.
// A utf-16 mark ends processing after the check. Results leave through the output registers,
// kept bytes also through the store read register; the last may follow busy falling.
// Reset clears count, state and strobes; the chunk store needs no clearing.
// ----------------------------------------------------------------------------
// utf8_chunk_boundary_sanitizer_core
// Collects a text chunk, handles byte order marks, trims a cut-off trailing
// utf-8 character and sends the cleaned bytes.
// ----------------------------------------------------------------------------
module utf8_chunk_boundary_sanitizer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 data_byte_i,
  input  logic                       chunk_end_i,
  input  logic                       at_file_start_i,
  input  logic                       more_follows_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o,
  output logic                       status_o,
  output logic [ucbs_pkg::LEN_W-1:0] valid_length_o
);
  import ucbs_pkg::*;

  ucbs_cmd_t cmd;
  ucbs_sts_t sts;

  ucbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .chunk_end_i (chunk_end_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  ucbs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (data_byte_i),
    .at_file_start_i (at_file_start_i),
    .more_follows_i  (more_follows_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o),
    .status_o        (status_o),
    .valid_length_o  (valid_length_o)
  );

endmodule

// ===== sv/ucbs_checker.sv =====
// ----------------------------------------------------------------------------
// ucbs_checker
// Port-level checks of the sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
module ucbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       chunk_end_i,
  input logic                       out_valid_o,
  input logic [7:0]                 out_byte_o,
  input logic                       out_last_o,
  input logic                       status_o,
  input logic [ucbs_pkg::LEN_W-1:0] valid_length_o
);

  // busy only starts after a transfer that closes a chunk
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && chunk_end_i))
    else $error("busy rose without a closing transfer");

  // utf-16 status result is a single zero byte ending the chunk
  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (out_last_o && out_byte_o == 8'h00))
    else $error("malformed status result");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_length_o != '0))
    else $error("zero valid_length on a result");

  // length stays the same across results of one chunk
  a_len_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |=> (out_valid_o && $stable(valid_length_o)))
    else $error("chunk results broken or length changed");

endmodule

bind utf8_chunk_boundary_sanitizer_core ucbs_checker u_ucbs_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the utf-8 chunk boundary sanitizer. Text chunks are fed
// one byte per transfer. A local model of the chunk store predicts every
// cleaned byte and every utf-16 status result. A checker compares each
// strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ucbs_pkg::*;

  typedef enum int unsigned {
    K_ASCII = 1,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4,
    K_BAD_LEAD
  } char_kind_e;

  localparam logic [1:0] CONT_TAG     = 2'b10;
  localparam logic [2:0] LEAD2_TAG    = 3'b110;
  localparam logic [3:0] LEAD3_TAG    = 4'b1110;
  localparam logic [4:0] LEAD4_TAG    = 5'b11110;
  localparam logic [4:0] BAD_LEAD_TAG = 5'b11111;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0]       b;
    logic             last;
    logic             utf16;
    logic [LEN_W-1:0] len;
  } clean_res_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [7:0]       data_byte_i;
  logic             chunk_end_i;
  logic             at_file_start_i;
  logic             more_follows_i;
  logic             out_valid_o;
  logic [7:0]       out_byte_o;
  logic             out_last_o;
  logic             status_o;
  logic [LEN_W-1:0] valid_length_o;

  // local copy of the chunk store and fill count
  logic [7:0]  text_mem [CHUNK_BYTES];
  int unsigned held_cnt;
  logic        chunk_overfull;

  clean_res_t  expected_out_q [$];
  clean_res_t  head_res;
  logic [7:0]  chunk_q [$];

  logic        gaps_on;
  int unsigned mismatch_cnt;
  int unsigned chunks_sent;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned utf16_chunks;
  int unsigned overfull_chunks;
  int unsigned trimmed_chunks;

  utf8_chunk_boundary_sanitizer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .data_byte_i    (data_byte_i),
    .chunk_end_i    (chunk_end_i),
    .at_file_start_i(at_file_start_i),
    .more_follows_i (more_follows_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .status_o       (status_o),
    .valid_length_o (valid_length_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // only the first few mismatches are printed, all are counted
  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINTED) begin
      $display("tb: mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // walk back over a cut-off trailing character, returns the kept length
  function automatic int unsigned kept_after_trim(input int unsigned n);
    int unsigned len;
    int unsigned tail;
    int unsigned want;
    logic [7:0]  b;
    len  = n;
    tail = 0;
    while (len > 0) begin
      b = text_mem[ADDR_W'(len - 1)];
      if (b[7] == 1'b0) begin
        break;
      end else if (b[7:6] == CONT_TAG) begin
        tail++;
        len--;
      end else begin
        want = 0;
        len--;
        if (b[7:5] == LEAD2_TAG) want = 1;
        else if (b[7:4] == LEAD3_TAG) want = 2;
        else if (b[7:3] == LEAD4_TAG) want = 3;
        if (tail == want) len += 1 + tail;
        break;
      end
    end
    return len;
  endfunction

  function automatic void predict_sanitized(input logic [7:0] b, input logic e,
                                            input logic fs, input logic mf);
    int unsigned n;
    int unsigned len;
    int unsigned i;
    logic [7:0]  c;
    clean_res_t  res;
    if (held_cnt < CHUNK_BYTES) begin
      text_mem[held_cnt[ADDR_W-1:0]] = b;
      held_cnt++;
    end else begin
      chunk_overfull = 1'b1;
    end
    if (!e) return;
    n        = held_cnt;
    held_cnt = 0;
    if (chunk_overfull) overfull_chunks++;
    chunk_overfull = 1'b0;
    if (fs && n >= 2 &&
        ((text_mem[0] == BYTE_FF && text_mem[1] == BYTE_FE) ||
         (text_mem[0] == BYTE_FE && text_mem[1] == BYTE_FF))) begin
      res.b     = '0;
      res.last  = 1'b1;
      res.utf16 = 1'b1;
      res.len   = n[LEN_W-1:0];
      expected_out_q.push_back(res);
      utf16_chunks++;
      return;
    end
    if (fs && n >= 3 && text_mem[0] == BOM8_B0 && text_mem[1] == BOM8_B1 &&
        text_mem[2] == BOM8_B2) begin
      text_mem[0] = BYTE_SPACE;
      text_mem[1] = BYTE_SPACE;
      text_mem[2] = BYTE_SPACE;
    end
    len = mf ? kept_after_trim(n) : n;
    if (len == 0) len = n;
    if (len < n) trimmed_chunks++;
    for (i = 0; i < len; i++) begin
      c = text_mem[i[ADDR_W-1:0]];
      if (c == BYTE_CR || c == BYTE_NUL) c = BYTE_SPACE;
      res.b     = c;
      res.last  = (i + 1 == len);
      res.utf16 = 1'b0;
      res.len   = len[LEN_W-1:0];
      expected_out_q.push_back(res);
    end
  endfunction

  // one byte transfer, with an optional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic e, input logic fs,
                           input logic mf);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        start           = 1'b0;
        data_byte_i     = 8'($urandom);
        chunk_end_i     = 1'($urandom_range(0, 1));
        at_file_start_i = 1'($urandom_range(0, 1));
        more_follows_i  = 1'($urandom_range(0, 1));
      end
    end
    @(negedge clk_i);
    start           = 1'b1;
    data_byte_i     = b;
    chunk_end_i     = e;
    at_file_start_i = fs;
    more_follows_i  = mf;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_sanitized(b, e, fs, mf);
    bytes_sent++;
  endtask

  task automatic send_chunk(input logic fs, input logic mf);
    int unsigned i;
    logic        last;
    for (i = 0; i < chunk_q.size(); i++) begin
      last = (i + 1 == chunk_q.size());
      send_byte(chunk_q[i], last,
                last ? fs : logic'($urandom_range(0, 1)),
                last ? mf : logic'($urandom_range(0, 1)));
    end
    chunk_q.delete();
    chunks_sent++;
  endtask

  // bytes given first to last in the upper bits of v
  task automatic send_bytes(input logic [63:0] v, input int unsigned n,
                            input logic fs, input logic mf);
    int unsigned i;
    for (i = 0; i < n; i++) chunk_q.push_back(v[8*(n-1-i) +: 8]);
    send_chunk(fs, mf);
  endtask

  function automatic void push_char(input int unsigned kind, input int unsigned conts);
    logic [7:0] b;
    b = 8'($urandom);
    case (kind)
      K_ASCII: b[7]   = 1'b0;
      K_LEAD2: b[7:5] = LEAD2_TAG;
      K_LEAD3: b[7:4] = LEAD3_TAG;
      K_LEAD4: b[7:3] = LEAD4_TAG;
      default: b[7:3] = BAD_LEAD_TAG;
    endcase
    chunk_q.push_back(b);
    repeat (conts) begin
      b      = 8'($urandom);
      b[7:6] = CONT_TAG;
      chunk_q.push_back(b);
    end
  endfunction

  task automatic test_plain_text();
    send_bytes(64'({8'h41, BYTE_CR, BYTE_NUL, 8'h7F, BYTE_FF}), 5, 1'b0, 1'b0);
    // single byte chunk at file start
    send_bytes({56'h0, BYTE_CR}, 1, 1'b1, 1'b1);
  endtask

  task automatic test_utf16_mark();
    send_bytes(64'({BYTE_FF, BYTE_FE}), 2, 1'b1, 1'b1);
    send_bytes(64'({BYTE_FE, BYTE_FF, 8'h41}), 3, 1'b1, 1'b0);
    // not at file start: plain bytes
    send_bytes(64'({BYTE_FF, BYTE_FE}), 2, 1'b0, 1'b1);
  endtask

  task automatic test_utf8_bom();
    send_bytes(64'({BOM8_B0, BOM8_B1, BOM8_B2, 8'h41}), 4, 1'b1, 1'b1);
    // too short to hold the mark
    send_bytes(64'({BOM8_B0, BOM8_B1}), 2, 1'b1, 1'b0);
  endtask

  task automatic test_cut_tail();
    send_bytes(64'({8'h41, 8'hE2, 8'h82}), 3, 1'b0, 1'b1);
    send_bytes(64'({8'h41, 8'hC3, 8'hA9}), 3, 1'b0, 1'b1);
  endtask

  task automatic test_empty_after_trim();
    send_bytes(64'({8'hF0, 8'h9F, 8'h98}), 3, 1'b0, 1'b1);
  endtask

  // mostly well-formed text with a cut tail now and then, plus noise
  task automatic test_random_chunks(input int unsigned budget);
    int unsigned sent;
    int unsigned k;
    int unsigned target;
    int unsigned r;
    int unsigned kind;
    logic        fs;
    logic        mf;
    logic [7:0]  b;
    sent = 0;
    k    = 0;
    while (sent < budget) begin
      gaps_on = (sent < budget * 2 / 3);
      fs      = ($urandom_range(0, 2) == 0);
      mf      = 1'($urandom_range(0, 1));
      if (k == 0) target = CHUNK_BYTES + 2;
      else if (k == 1) target = CHUNK_BYTES;
      else if ($urandom_range(0, 11) == 0) target = $urandom_range(56, 70);
      else target = $urandom_range(1, 14);
      if (fs && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            chunk_q.push_back(BYTE_FF);
            chunk_q.push_back(BYTE_FE);
          end
          1: begin
            chunk_q.push_back(BYTE_FE);
            chunk_q.push_back(BYTE_FF);
          end
          2: begin
            chunk_q.push_back(BOM8_B0);
            chunk_q.push_back(BOM8_B1);
            chunk_q.push_back(BOM8_B2);
          end
          default: begin
            chunk_q.push_back(BOM8_B0);
            chunk_q.push_back(BOM8_B1);
            chunk_q.push_back(8'($urandom));
          end
        endcase
      end
      while (chunk_q.size() < target) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          push_char(K_ASCII, 0);
        end else if (r < 40) begin
          chunk_q.push_back(r[0] ? BYTE_CR : BYTE_NUL);
        end else if (r < 70) begin
          kind = $urandom_range(K_LEAD2, K_LEAD4);
          push_char(kind, kind - 1);
        end else if (r < 80) begin
          chunk_q.push_back(8'($urandom));
        end else if (r < 90) begin
          push_char(K_BAD_LEAD, $urandom_range(0, 3));
        end else begin
          b      = 8'($urandom);
          b[7:6] = CONT_TAG;
          chunk_q.push_back(b);
        end
      end
      while (chunk_q.size() > target) void'(chunk_q.pop_back());
      // cut-off or over-long trailing character, never on the exactly full chunk
      if (k != 1 && $urandom_range(0, 1) == 1) begin
        kind = $urandom_range(K_LEAD2, K_BAD_LEAD);
        push_char(kind, $urandom_range(0, 3));
      end
      sent += chunk_q.size();
      send_chunk(fs, mf);
      k++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_out_q.size() == 0) begin
        report_mismatch($sformatf("result byte %02h with nothing expected", out_byte_o));
      end else begin
        head_res = expected_out_q.pop_front();
        results_checked++;
        if (out_byte_o !== head_res.b)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, head_res.b));
        if (out_last_o !== head_res.last)
          report_mismatch($sformatf("out_last %b, expected %b", out_last_o, head_res.last));
        if (status_o !== head_res.utf16)
          report_mismatch($sformatf("status %b, expected %b", status_o, head_res.utf16));
        if (valid_length_o !== head_res.len)
          report_mismatch($sformatf("valid_length %0d, expected %0d", valid_length_o,
                                    head_res.len));
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    data_byte_i     = '0;
    chunk_end_i     = 1'b0;
    at_file_start_i = 1'b0;
    more_follows_i  = 1'b0;
    held_cnt        = 0;
    chunk_overfull  = 1'b0;
    gaps_on         = 1'b1;
    mismatch_cnt    = 0;
    chunks_sent     = 0;
    bytes_sent      = 0;
    results_checked = 0;
    utf16_chunks    = 0;
    overfull_chunks = 0;
    trimmed_chunks  = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_text();
    test_utf16_mark();
    test_utf8_bom();
    test_cut_tail();
    test_empty_after_trim();
    test_random_chunks(300);

    @(negedge clk_i);
    start = 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    // catch stray results after the last expected one
    repeat (20) @(posedge clk_i);

    $display("tb: %0d chunks of %0d bytes sent, %0d results checked", chunks_sent,
             bytes_sent, results_checked);
    $display("tb: %0d utf-16 marks, %0d overfull chunks, %0d chunks with a cut tail",
             utf16_chunks, overfull_chunks, trimmed_chunks);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
